[hw/rtl/wsfu_pkg.sv]
// ----------------------------------------------------------------------------
// wsfu_pkg
// Shared types and constants for the websocket frame unmasker.
// ----------------------------------------------------------------------------
package wsfu_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] HDR_FIN_BIT  = 8'h80;
	localparam logic [7:0] HDR_OPCODE   = 8'h0F;
	localparam logic [7:0] HDR_MASK_BIT = 8'h80;
	localparam logic [7:0] HDR_LEN7     = 8'h7F;
	localparam logic [6:0] LEN7_EXT16   = 7'd126;
	localparam logic [6:0] LEN7_EXT64   = 7'd127;

	localparam logic [1:0] ST_DATA     = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_UNMASKED = 2'd2;
	localparam logic [1:0] ST_LONG64   = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_LEN     = 4'd1,
		PH_EXT_HI  = 4'd2,
		PH_EXT_LO  = 4'd3,
		PH_KEY0    = 4'd4,
		PH_KEY1    = 4'd5,
		PH_KEY2    = 4'd6,
		PH_KEY3    = 4'd7,
		PH_PAYLOAD = 4'd8
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_byte;
		logic [1:0] status;
		logic [3:0] frame_opcode;
		logic       final_fragment;
	} result_t;

	// work handed from the parser to the back end
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
		logic [1:0] status;
		logic [3:0] opcode;
		logic       fin;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

[hw/rtl/wsfu_front.sv]
// ----------------------------------------------------------------------------
// wsfu_front
// Header parser: tracks frame phase, captures length and key, and turns each
// accepted byte that yields a result into a command for the back end.
// ----------------------------------------------------------------------------
module wsfu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  wsfu_pkg::item_t      item,
	output logic                 cmd_valid,
	output wsfu_pkg::cmd_t       cmd
);

	wsfu_pkg::phase_t phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] done_q, done_d;
	logic [31:0] key_q, key_d;
	logic [3:0]  op_q, op_d;
	logic        fin_q, fin_d;

	logic [15:0] done_inc;
	logic [7:0]  key_sel;
	logic [6:0]  len7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsfu_pkg::PH_IDLE;
			len_q   <= '0;
			done_q  <= '0;
			key_q   <= '0;
			op_q    <= '0;
			fin_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			done_q  <= done_d;
			key_q   <= key_d;
			op_q    <= op_d;
			fin_q   <= fin_d;
		end
	end

	assign done_inc = done_q + 16'd1;
	assign len7     = item.data_byte[6:0] & wsfu_pkg::HDR_LEN7[6:0];

	always_comb begin
		case (done_q[1:0])
			2'd0:    key_sel = key_q[31:24];
			2'd1:    key_sel = key_q[23:16];
			2'd2:    key_sel = key_q[15:8];
			default: key_sel = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		len_d      = len_q;
		done_d     = done_q;
		key_d      = key_q;
		op_d       = op_q;
		fin_d      = fin_q;
		cmd_valid  = 1'b0;
		cmd.data   = '0;
		cmd.key    = '0;
		cmd.last   = 1'b1;
		cmd.status = wsfu_pkg::ST_DATA;
		cmd.opcode = op_q;
		cmd.fin    = fin_q;
		if (accept) begin
			if (item.frame_start) begin
				fin_d   = |(item.data_byte & wsfu_pkg::HDR_FIN_BIT);
				op_d    = 4'(item.data_byte & wsfu_pkg::HDR_OPCODE);
				len_d   = '0;
				done_d  = '0;
				key_d   = '0;
				phase_d = wsfu_pkg::PH_LEN;
			end else begin
				case (phase_q)
					wsfu_pkg::PH_IDLE: begin
					end
					wsfu_pkg::PH_LEN: begin
						if ((item.data_byte & wsfu_pkg::HDR_MASK_BIT) == 8'h00) begin
							phase_d    = wsfu_pkg::PH_IDLE;
							cmd_valid  = 1'b1;
							cmd.status = wsfu_pkg::ST_UNMASKED;
						end else if (len7 == wsfu_pkg::LEN7_EXT64) begin
							phase_d    = wsfu_pkg::PH_IDLE;
							cmd_valid  = 1'b1;
							cmd.status = wsfu_pkg::ST_LONG64;
						end else if (len7 == wsfu_pkg::LEN7_EXT16) begin
							phase_d = wsfu_pkg::PH_EXT_HI;
						end else begin
							len_d   = {9'd0, len7};
							phase_d = wsfu_pkg::PH_KEY0;
						end
					end
					wsfu_pkg::PH_EXT_HI: begin
						len_d   = {item.data_byte, 8'h00};
						phase_d = wsfu_pkg::PH_EXT_LO;
					end
					wsfu_pkg::PH_EXT_LO: begin
						len_d   = {len_q[15:8], item.data_byte};
						phase_d = wsfu_pkg::PH_KEY0;
					end
					wsfu_pkg::PH_KEY0, wsfu_pkg::PH_KEY1, wsfu_pkg::PH_KEY2: begin
						key_d   = {key_q[23:0], item.data_byte};
						phase_d = wsfu_pkg::phase_t'(phase_q + 4'd1);
					end
					wsfu_pkg::PH_KEY3: begin
						key_d  = {key_q[23:0], item.data_byte};
						done_d = '0;
						if (len_q == 16'd0) begin
							phase_d    = wsfu_pkg::PH_IDLE;
							cmd_valid  = 1'b1;
							cmd.status = wsfu_pkg::ST_EMPTY;
						end else begin
							phase_d = wsfu_pkg::PH_PAYLOAD;
						end
					end
					wsfu_pkg::PH_PAYLOAD: begin
						done_d    = done_inc;
						cmd_valid = 1'b1;
						cmd.data  = item.data_byte;
						cmd.key   = key_sel;
						cmd.last  = (done_inc == len_q);
						if (done_inc == len_q) begin
							phase_d = wsfu_pkg::PH_IDLE;
						end
					end
					default: begin
						phase_d = wsfu_pkg::PH_IDLE;
					end
				endcase
			end
		end
	end

endmodule

[hw/rtl/wsfu_fifo.sv]
// ----------------------------------------------------------------------------
// wsfu_fifo
// Short command queue between parser and back end.
// ----------------------------------------------------------------------------
module wsfu_fifo #(
	parameter int unsigned DEPTH = wsfu_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  wsfu_pkg::cmd_t   wr_data,
	input  logic             rd_en,
	output wsfu_pkg::cmd_t   rd_data,
	output wsfu_pkg::qstat_t stat
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	wsfu_pkg::cmd_t mem_q [DEPTH];
	logic [PtrW-1:0] wptr_q, rptr_q;
	logic [CntW-1:0] count_q;
	logic do_wr, do_rd;

	assign stat.full  = (count_q == CntW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

[hw/rtl/wsfu_back.sv]
// ----------------------------------------------------------------------------
// wsfu_back
// Back end: unmasks payload bytes and holds the result beat for the receiver.
// ----------------------------------------------------------------------------
module wsfu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wsfu_pkg::cmd_t    cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output wsfu_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);

	wsfu_pkg::result_t res_q;
	logic              valid_q;

	assign cmd_pop = !cmd_empty && (!valid_q || pop);
	assign result  = res_q;
	assign empty   = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_q.payload_byte   <= (cmd.status == wsfu_pkg::ST_DATA) ?
			                        (cmd.data ^ cmd.key) : 8'h00;
			res_q.last_byte      <= cmd.last;
			res_q.status         <= cmd.status;
			res_q.frame_opcode   <= cmd.opcode;
			res_q.final_fragment <= cmd.fin;
		end
	end

endmodule

[hw/rtl/websocket_frame_unmasker_top.sv]
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_top
// Receive-side frame parser and payload unmasker, one byte per beat.
// ----------------------------------------------------------------------------
// Input: a byte stream with frame_start on the first header byte of a frame;
// a beat is taken when push is high and full is low. Results: while empty is
// low the oldest result sits on result; pop takes it. Each payload byte gives
// one data result (last_byte marks the end); an empty frame gives one result
// with status empty; an unmasked frame or a 64-bit length gives one error
// result, after which bytes are dropped until the next frame start.
// Path: the parser writes the command queue at the accepting edge, and the
// queue loads the output register when it is empty or being popped.
// Throughput: one byte per cycle, with push and pop in the same cycle.
// A stalled receiver fills the output register and then the command queue
// (QUEUE_DEPTH entries); full then rises and holds the sender.
// Reset clears the parser to wait for a frame start and empties the queue
// and the output register.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_top #(
	parameter int unsigned QUEUE_DEPTH = wsfu_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wsfu_pkg::item_t   item,
	input  logic              push,
	output logic              full,
	output wsfu_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);

	logic             accept;
	logic             cmd_valid;
	wsfu_pkg::cmd_t   cmd_in, cmd_out;
	logic             cmd_pop;
	wsfu_pkg::qstat_t q_stat;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	wsfu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	wsfu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.stat    (q_stat)
	);

	wsfu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (q_stat.empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != wsfu_pkg::ST_DATA |-> result.payload_byte == 8'h00)
		else $error("non-data result carries a payload byte");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != wsfu_pkg::ST_DATA |-> result.last_byte)
		else $error("non-data result not marked last");

	a_cmd_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && q_stat.empty |=> !q_stat.empty || !empty)
		else $error("parsed command lost");

endmodule

[verif/unmask_checker.sv]
// ----------------------------------------------------------------------------
// unmask_checker
// Watches the byte and result channels of the frame unmasker. Keeps its own
// model of the header parser and key, queues the expected result of each
// accepted byte and compares every popped result field by field.
// ----------------------------------------------------------------------------
module unmask_checker
	import wsfu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       item,
	input  logic        push,
	input  logic        full,
	input  result_t     result,
	input  logic        empty,
	input  logic        pop,
	output int unsigned mismatches,
	output int unsigned pending
);

	phase_t      phase;
	logic [15:0] frame_len;
	logic [15:0] byte_idx;
	logic [31:0] key_word;
	logic [3:0]  cur_opcode;
	logic        cur_fin;
	result_t     expected_q[$];

	function automatic result_t make_result(input logic [7:0] b, input logic last,
			input logic [1:0] st);
		result_t r;
		r.payload_byte   = b;
		r.last_byte      = last;
		r.status         = st;
		r.frame_opcode   = cur_opcode;
		r.final_fragment = cur_fin;
		return r;
	endfunction

	// advances the parser by one byte; returns 1 when the byte yields a result
	function automatic bit unmask_step(input item_t it, output result_t r);
		logic [7:0] b;
		logic [6:0] len7;
		logic [7:0] kb;
		b = it.data_byte;
		r = '0;
		if (it.frame_start) begin
			cur_fin    = (b & HDR_FIN_BIT) != 8'h00;
			cur_opcode = 4'(b & HDR_OPCODE);
			frame_len  = '0;
			byte_idx   = '0;
			key_word   = '0;
			phase      = PH_LEN;
			return 1'b0;
		end
		case (phase)
			PH_LEN: begin
				len7 = 7'(b & HDR_LEN7);
				if ((b & HDR_MASK_BIT) == 8'h00) begin
					phase = PH_IDLE;
					r = make_result(8'h00, 1'b1, ST_UNMASKED);
					return 1'b1;
				end
				if (len7 == LEN7_EXT64) begin
					phase = PH_IDLE;
					r = make_result(8'h00, 1'b1, ST_LONG64);
					return 1'b1;
				end
				if (len7 == LEN7_EXT16) begin
					phase = PH_EXT_HI;
				end else begin
					frame_len = 16'(len7);
					phase = PH_KEY0;
				end
			end
			PH_EXT_HI: begin
				frame_len = {b, 8'h00};
				phase = PH_EXT_LO;
			end
			PH_EXT_LO: begin
				frame_len[7:0] = b;
				phase = PH_KEY0;
			end
			PH_KEY0, PH_KEY1, PH_KEY2: begin
				key_word = {key_word[23:0], b};
				phase = phase_t'(phase + 4'd1);
			end
			PH_KEY3: begin
				key_word = {key_word[23:0], b};
				byte_idx = '0;
				if (frame_len == 16'd0) begin
					phase = PH_IDLE;
					r = make_result(8'h00, 1'b1, ST_EMPTY);
					return 1'b1;
				end
				phase = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				kb = 8'(key_word >> (8 * (3 - byte_idx[1:0])));
				byte_idx = byte_idx + 16'd1;
				if (byte_idx == frame_len) begin
					phase = PH_IDLE;
				end
				r = make_result(b ^ kb, byte_idx == frame_len, ST_DATA);
				return 1'b1;
			end
			default: begin
				phase = PH_IDLE;
			end
		endcase
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			phase      = PH_IDLE;
			frame_len  = '0;
			byte_idx   = '0;
			key_word   = '0;
			cur_opcode = '0;
			cur_fin    = 1'b0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: unexpected beat byte=%02h last=%0d status=%0d op=%0h fin=%0d",
							$realtime, result.payload_byte, result.last_byte, result.status,
							result.frame_opcode, result.final_fragment);
					end
					mismatches <= mismatches + 1;
				end else begin
					want = expected_q.pop_front();
					if (result.payload_byte !== want.payload_byte
							|| result.last_byte !== want.last_byte
							|| result.status !== want.status
							|| result.frame_opcode !== want.frame_opcode
							|| result.final_fragment !== want.final_fragment) begin
						if (mismatches < 10) begin
							$display("%0t: mismatch exp byte=%02h last=%0d status=%0d op=%0h fin=%0d",
								$realtime, want.payload_byte, want.last_byte, want.status,
								want.frame_opcode, want.final_fragment);
							$display("%0t:          got byte=%02h last=%0d status=%0d op=%0h fin=%0d",
								$realtime, result.payload_byte, result.last_byte, result.status,
								result.frame_opcode, result.final_fragment);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			if (push && !full) begin
				if (unmask_step(item, fresh)) begin
					expected_q.push_back(fresh);
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the websocket frame unmasker. Sends directed frames (empty,
// unmasked, 64-bit length, 16-bit length, short payload) and then random
// frames, truncated frames, error frames and stray bytes, with random gaps
// on the byte side and random stalls on the result side. Checking is done by
// unmask_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import wsfu_pkg::*;

	logic        clk;
	logic        arst_n;
	item_t       item = '0;
	logic        push = 1'b0;
	logic        full;
	result_t     result;
	logic        empty;
	logic        pop = 1'b0;
	int unsigned mismatches;
	int unsigned pending;

	bit          calm;
	bit          pop_calm;
	bit          draining = 1'b0;
	int          pop_hold = 0;
	int          n_sent = 0;

	websocket_frame_unmasker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

	unmask_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push       (push),
		.full       (full),
		.result     (result),
		.empty      (empty),
		.pop        (pop),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (draining) begin
			pop <= 1'b1;
		end else if (pop_hold != 0) begin
			pop <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 63) == 0) begin
				pop_calm <= !pop_calm;
			end
			if (!pop_calm && $urandom_range(0, 5) == 0) begin
				pop_hold <= rand_gap();
			end
		end
	end

	task automatic put_beat(input logic [7:0] b, input logic s);
		int gap;
		gap = calm ? 0 : rand_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= '{data_byte: b, frame_start: s};
		push <= 1'b1;
		do @(posedge clk); while (full);
		n_sent++;
	endtask

	task automatic send_noise(input int n);
		repeat (n) put_beat(8'($urandom), 1'b0);
	endtask

	// masked frame; body_n may differ from len, chop cuts it short at random
	task automatic send_masked(input logic [7:0] hdr0, input bit wide, input logic [15:0] len,
			input logic [31:0] key, input int body_n, input bit chop);
		logic [7:0] bytes_q[$];
		int         cut;
		bytes_q.push_back(hdr0);
		if (wide || len >= 16'd126) begin
			bytes_q.push_back(HDR_MASK_BIT | 8'(LEN7_EXT16));
			bytes_q.push_back(len[15:8]);
			bytes_q.push_back(len[7:0]);
		end else begin
			bytes_q.push_back(HDR_MASK_BIT | len[7:0]);
		end
		for (int i = 0; i < 4; i++) begin
			bytes_q.push_back(key[31 - 8 * i -: 8]);
		end
		repeat (body_n) bytes_q.push_back(8'($urandom));
		cut = chop ? $urandom_range(1, bytes_q.size() - 1) : bytes_q.size();
		for (int i = 0; i < cut; i++) begin
			put_beat(bytes_q[i], i == 0);
		end
	endtask

	function automatic logic [15:0] pick_len(input bit wide);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 16'd0;
		if (r < 80) return 16'($urandom_range(1, 12));
		if (r < 95 || !wide) return 16'($urandom_range(13, 125));
		return 16'($urandom_range(126, 300));
	endfunction

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [7:0]  hdr0;
		logic [31:0] key;
		logic [15:0] len;
		bit          wide;
		int          pick;
		arst_n = 1'b0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_noise(1);
		put_beat(8'h8F, 1'b1);
		put_beat(8'h05, 1'b0);
		put_beat(8'hAA, 1'b0);
		put_beat(8'h00, 1'b1);
		put_beat(8'hFF, 1'b0);
		send_masked(8'h81, 1'b0, 16'd0, 32'h1234_5678, 0, 1'b0);
		send_masked(8'h02, 1'b1, 16'd0, 32'h0000_0000, 0, 1'b0);
		send_masked(8'h8A, 1'b0, 16'd1, 32'hFFFF_FFFF, 1, 1'b0);
		send_masked(8'h7F, 1'b1, 16'd5, 32'hA5C3_0F96, 5, 1'b0);

		// random
		while (n_sent < 1900) begin
			calm = ($urandom_range(0, 3) == 0);
			hdr0 = 8'($urandom);
			key  = $urandom;
			wide = ($urandom_range(0, 3) == 0);
			len  = pick_len(wide);
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				send_masked(hdr0, wide, len, key, len, 1'b0);
			end else if (pick < 78) begin
				send_masked(hdr0, wide, len, key, len, 1'b1);
			end else if (pick < 86) begin
				put_beat(hdr0, 1'b1);
				put_beat({1'b0, 7'($urandom)}, 1'b0);
				send_noise($urandom_range(0, 4));
			end else if (pick < 91) begin
				put_beat(hdr0, 1'b1);
				put_beat(HDR_MASK_BIT | 8'(LEN7_EXT64), 1'b0);
				send_noise($urandom_range(0, 4));
			end else if (pick < 93) begin
				send_masked(hdr0, 1'b1, 16'hFFFF, key, $urandom_range(0, 30), 1'b0);
			end else begin
				send_noise($urandom_range(1, 4));
			end
		end

		push <= 1'b0;
		draining <= 1'b1;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
